### rtl/pst_pkg.sv
// Shared constants and codes for the spanning tree engine.
package pst_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int COST_BITS_DEF = 16;

    localparam int NODE_W  = 6;
    localparam int PORT_CW = 16;
    localparam int COUNT_W = 7;
    localparam int SUM_W   = 22;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_RUN   = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_REJECT     = 2'd1,
        ST_DISCONN    = 2'd2,
        ST_BAD_START  = 2'd3
    } status_t;

endpackage

### rtl/pst_ram.sv
// Simple dual-port RAM: one write port, one registered read port with enable.
module pst_ram #(
    parameter int W  = 16,
    parameter int AW = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [2**AW];
    logic [W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while the enable is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/pst_relax.sv
// Shared compare unit: relaxes one link cost and tracks the running minimum.
module pst_relax #(
    parameter int COST_BITS = 16
) (
    input  logic [COST_BITS-1:0] m,
    input  logic [COST_BITS-1:0] d,
    input  logic                 vis,
    input  logic                 found,
    input  logic [COST_BITS-1:0] min_cost,
    output logic                 upd,
    output logic [COST_BITS-1:0] newd,
    output logic                 take
);

    // Lower the link cost when the matrix entry beats it
    assign upd  = !vis && (m < d);
    assign newd = upd ? m : d;

    // Keep the first strictly smaller unvisited cost
    assign take = !vis && (!found || (newd < min_cost));

endmodule

### rtl/prim_spanning_tree_engine.sv
// Top level: cost matrix store and Prim sequencer around one shared compare unit.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    kind node_a node_b cost_value start_node
// out      output     out_valid / out_ready  edge_parent edge_child edge_cost has_edge
//                                            total_cost read_value status last
// cfg      input      cfg_valid / cfg_ready  cfg_data (node_count)
//
// A run sweeps the matrix row of each added node through one RAM read port,
// then emits its edges in the order the nodes were added.
// Reset, a clear and a node_count write sweep the whole matrix, one entry a cycle;
// no item is accepted meanwhile.
// A stalled output holds the sequencer at its next result; in_ready is low until idle.
module prim_spanning_tree_engine #(
    parameter int MAX_NODES = pst_pkg::MAX_NODES_DEF,
    parameter int COST_BITS = pst_pkg::COST_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  kind,
    input  logic [pst_pkg::NODE_W-1:0]  node_a,
    input  logic [pst_pkg::NODE_W-1:0]  node_b,
    input  logic [pst_pkg::PORT_CW-1:0] cost_value,
    input  logic [pst_pkg::NODE_W-1:0]  start_node,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [pst_pkg::NODE_W-1:0]  edge_parent,
    output logic [pst_pkg::NODE_W-1:0]  edge_child,
    output logic [pst_pkg::PORT_CW-1:0] edge_cost,
    output logic                        has_edge,
    output logic [pst_pkg::SUM_W-1:0]   total_cost,
    output logic [pst_pkg::PORT_CW-1:0] read_value,
    output logic [1:0]                  status,
    output logic                        last,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pst_pkg::COUNT_W-1:0] cfg_data
);

    localparam int IDXW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NW   = $clog2(MAX_NODES + 1);
    localparam int MAW  = 2 * IDXW;
    localparam int CW   = (NW > pst_pkg::NODE_W) ? NW : pst_pkg::NODE_W;
    localparam int NCW  = (NW > pst_pkg::COUNT_W) ? NW : pst_pkg::COUNT_W;
    localparam int KW   = (COST_BITS > pst_pkg::PORT_CW) ? COST_BITS : pst_pkg::PORT_CW;
    localparam int XW   = (COST_BITS > pst_pkg::SUM_W) ? COST_BITS : pst_pkg::SUM_W;
    localparam int LW   = COST_BITS + IDXW;
    localparam logic [COST_BITS-1:0] NO_EDGE = '1;

    typedef enum logic [10:0] {
        S_SWEEP  = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_WR2    = 11'b00000000100,
        S_RDWAIT = 11'b00000001000,
        S_REPLY  = 11'b00000010000,
        S_PASS   = 11'b00000100000,
        S_SELECT = 11'b00001000000,
        S_ORD    = 11'b00010000000,
        S_LNK    = 11'b00100000000,
        S_EDGE   = 11'b01000000000,
        S_SPARE  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [pst_pkg::COUNT_W-1:0] node_count_reg;
    logic [MAW-1:0]              sweep_cnt_reg;
    logic                        sweep_reply_reg;
    logic [IDXW-1:0]             a_reg, b_reg;
    logic [COST_BITS-1:0]        wcost_reg;
    logic [1:0]                  pend_st_reg;
    logic [pst_pkg::PORT_CW-1:0] pend_rv_reg;
    logic [MAX_NODES-1:0]        visited_reg;
    logic [IDXW-1:0]             best_reg;
    logic                        init_reg;
    logic [NW-1:0]               iss_reg;
    logic                        p_valid_reg;
    logic [IDXW-1:0]             p_idx_reg;
    logic                        found_reg;
    logic [COST_BITS-1:0]        min_reg;
    logic [IDXW-1:0]             min_idx_reg;
    logic [NW-1:0]               added_reg;
    logic [pst_pkg::SUM_W-1:0]   sum_reg;
    logic [NW-1:0]               k_reg;
    logic [IDXW-1:0]             ch_reg;

    logic                        out_valid_reg;
    logic [pst_pkg::NODE_W-1:0]  edge_parent_reg, edge_child_reg;
    logic [pst_pkg::PORT_CW-1:0] edge_cost_reg, read_value_reg;
    logic                        has_edge_reg, last_reg;
    logic [pst_pkg::SUM_W-1:0]   total_cost_reg;
    logic [1:0]                  status_reg;

    // Effective node count, saturated to 1..MAX_NODES
    logic [NW-1:0] n_eff;
    always_comb
    begin
        if (node_count_reg == '0)
            n_eff = NW'(1);
        else if (NCW'(node_count_reg) > NCW'(MAX_NODES))
            n_eff = NW'(MAX_NODES);
        else
            n_eff = NW'(node_count_reg);
    end

    logic in_acc, cfg_acc, slot_free, out_load;
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign in_acc    = in_valid && in_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_load  = ((state_reg == S_REPLY) || (state_reg == S_EDGE)) && slot_free;

    // Decode the incoming item
    logic a_ok, b_ok, s_ok, cost_ok, wr_ok;
    logic [IDXW-1:0] a_idx, b_idx, s_idx;
    assign a_ok    = CW'(node_a) < CW'(n_eff);
    assign b_ok    = CW'(node_b) < CW'(n_eff);
    assign s_ok    = CW'(start_node) < CW'(n_eff);
    assign cost_ok = KW'(cost_value) < KW'(NO_EDGE);
    assign wr_ok   = a_ok && b_ok && (node_a != node_b) && cost_ok;
    assign a_idx   = IDXW'(node_a);
    assign b_idx   = IDXW'(node_b);
    assign s_idx   = IDXW'(start_node);

    // Pass control
    logic issuing, pass_done, sweep_done, last_add, fin;
    assign issuing    = (state_reg == S_PASS) && (iss_reg < n_eff);
    assign pass_done  = (state_reg == S_PASS) && !issuing && !p_valid_reg;
    assign sweep_done = sweep_cnt_reg == '1;
    assign last_add   = ({1'b0, added_reg} + 1'b1) == ({1'b0, n_eff} - 1'b1);
    assign fin        = ({1'b0, k_reg} + 1'b1) == {1'b0, added_reg};

    // Memories
    logic                 mat_we, mat_re;
    logic [MAW-1:0]       mat_waddr, mat_raddr;
    logic [COST_BITS-1:0] mat_wdata, mat_rd;
    logic                 lnk_we, lnk_re;
    logic [IDXW-1:0]      lnk_waddr, lnk_raddr;
    logic [LW-1:0]        lnk_wdata, lnk_rd;
    logic                 ord_we, ord_re;
    logic [IDXW-1:0]      ord_rd;

    logic                 upd, take;
    logic [COST_BITS-1:0] newd, d_cur;

    assign d_cur = init_reg ? NO_EDGE : lnk_rd[COST_BITS-1:0];

    pst_relax #(.COST_BITS(COST_BITS)) u_relax (
        .m        (mat_rd),
        .d        (d_cur),
        .vis      (visited_reg[p_idx_reg]),
        .found    (found_reg),
        .min_cost (min_reg),
        .upd      (upd),
        .newd     (newd),
        .take     (take)
    );

    // Matrix port selection
    always_comb
    begin
        mat_we    = 1'b0;
        mat_waddr = {a_idx, b_idx};
        mat_wdata = COST_BITS'(cost_value);
        mat_re    = 1'b0;
        mat_raddr = {a_idx, b_idx};
        if (state_reg == S_SWEEP)
        begin
            mat_we    = 1'b1;
            mat_waddr = sweep_cnt_reg;
            mat_wdata = (sweep_cnt_reg[MAW-1:IDXW] == sweep_cnt_reg[IDXW-1:0])
                        ? '0 : NO_EDGE;
        end
        else if (state_reg == S_WR2)
        begin
            mat_we    = 1'b1;
            mat_waddr = {b_reg, a_reg};
            mat_wdata = wcost_reg;
        end
        else if (in_acc && (kind == pst_pkg::KIND_WRITE) && wr_ok)
        begin
            mat_we = 1'b1;
        end
        if (issuing)
        begin
            mat_re    = 1'b1;
            mat_raddr = {best_reg, iss_reg[IDXW-1:0]};
        end
        else if (in_acc && (kind == pst_pkg::KIND_READ) && a_ok && b_ok)
        begin
            mat_re = 1'b1;
        end
    end

    // Link cost and parent port selection
    assign lnk_we    = p_valid_reg && (init_reg || upd);
    assign lnk_waddr = p_idx_reg;
    assign lnk_wdata = {(upd ? best_reg : IDXW'(0)), newd};
    assign lnk_re    = issuing || (state_reg == S_LNK);
    assign lnk_raddr = issuing ? iss_reg[IDXW-1:0] : ord_rd;

    assign ord_we = (state_reg == S_SELECT) && found_reg && (min_reg < NO_EDGE);
    assign ord_re = state_reg == S_ORD;

    pst_ram #(.W(COST_BITS), .AW(MAW)) u_matrix (
        .clk   (clk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (mat_wdata),
        .re    (mat_re),
        .raddr (mat_raddr),
        .rdata (mat_rd)
    );

    pst_ram #(.W(LW), .AW(IDXW)) u_link (
        .clk   (clk),
        .we    (lnk_we),
        .waddr (lnk_waddr),
        .wdata (lnk_wdata),
        .re    (lnk_re),
        .raddr (lnk_raddr),
        .rdata (lnk_rd)
    );

    pst_ram #(.W(IDXW), .AW(IDXW)) u_order (
        .clk   (clk),
        .we    (ord_we),
        .waddr (added_reg[IDXW-1:0]),
        .wdata (min_idx_reg),
        .re    (ord_re),
        .raddr (k_reg[IDXW-1:0]),
        .rdata (ord_rd)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_SWEEP:
                if (sweep_done)
                    state_next = sweep_reply_reg ? S_REPLY : S_IDLE;
            S_IDLE:
                if (in_acc)
                begin
                    unique case (kind)
                        pst_pkg::KIND_WRITE: state_next = wr_ok ? S_WR2 : S_REPLY;
                        pst_pkg::KIND_READ:  state_next = (a_ok && b_ok) ? S_RDWAIT : S_REPLY;
                        pst_pkg::KIND_CLEAR: state_next = S_SWEEP;
                        default:
                            state_next = (!s_ok || (n_eff == NW'(1))) ? S_REPLY : S_PASS;
                    endcase
                end
            S_WR2:    state_next = S_REPLY;
            S_RDWAIT: state_next = S_REPLY;
            S_REPLY:
                if (slot_free)
                    state_next = S_IDLE;
            S_PASS:
                if (pass_done)
                    state_next = S_SELECT;
            S_SELECT:
                if (!found_reg)
                    state_next = S_ORD;
                else if (min_reg >= NO_EDGE)
                    state_next = S_REPLY;
                else
                    state_next = last_add ? S_ORD : S_PASS;
            S_ORD:  state_next = S_LNK;
            S_LNK:  state_next = S_EDGE;
            S_EDGE:
                if (slot_free)
                    state_next = fin ? S_IDLE : S_ORD;
            default: state_next = S_IDLE;
        endcase
        if (cfg_acc)
            state_next = S_SWEEP;
    end

    logic [XW-1:0]           min_x;
    logic [KW-1:0]           dist_x;
    logic [pst_pkg::NODE_W+IDXW-1:0] par_x;
    assign min_x  = XW'(min_reg);
    assign dist_x = KW'(lnk_rd[COST_BITS-1:0]);
    assign par_x  = {{pst_pkg::NODE_W{1'b0}}, lnk_rd[LW-1:COST_BITS]};

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_SWEEP;
            node_count_reg  <= pst_pkg::COUNT_W'(1);
            sweep_cnt_reg   <= '0;
            sweep_reply_reg <= 1'b0;
            a_reg           <= '0;
            b_reg           <= '0;
            wcost_reg       <= '0;
            pend_st_reg     <= pst_pkg::ST_OK;
            pend_rv_reg     <= '0;
            visited_reg     <= '0;
            best_reg        <= '0;
            init_reg        <= 1'b0;
            iss_reg         <= '0;
            p_valid_reg     <= 1'b0;
            p_idx_reg       <= '0;
            found_reg       <= 1'b0;
            min_reg         <= '0;
            min_idx_reg     <= '0;
            added_reg       <= '0;
            sum_reg         <= '0;
            k_reg           <= '0;
            ch_reg          <= '0;
            out_valid_reg   <= 1'b0;
            edge_parent_reg <= '0;
            edge_child_reg  <= '0;
            edge_cost_reg   <= '0;
            has_edge_reg    <= 1'b0;
            total_cost_reg  <= '0;
            read_value_reg  <= '0;
            status_reg      <= pst_pkg::ST_OK;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Load a new result or retire an accepted one
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_SWEEP:
                    if (!cfg_acc)
                        sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                S_IDLE:
                    if (in_acc)
                    begin
                        a_reg       <= a_idx;
                        b_reg       <= b_idx;
                        wcost_reg   <= COST_BITS'(cost_value);
                        // Preload the read value and status of a single reply
                        if ((kind == pst_pkg::KIND_READ) && !(a_ok && b_ok))
                            pend_rv_reg <= pst_pkg::PORT_CW'(KW'(NO_EDGE)
                                                             >> (KW - pst_pkg::PORT_CW));
                        else
                            pend_rv_reg <= '0;
                        if ((kind == pst_pkg::KIND_WRITE) && !wr_ok)
                            pend_st_reg <= pst_pkg::ST_REJECT;
                        else if ((kind == pst_pkg::KIND_RUN) && !s_ok)
                            pend_st_reg <= pst_pkg::ST_BAD_START;
                        else
                            pend_st_reg <= pst_pkg::ST_OK;
                        if (kind == pst_pkg::KIND_CLEAR)
                        begin
                            sweep_cnt_reg   <= '0;
                            sweep_reply_reg <= 1'b1;
                        end
                        else if (kind == pst_pkg::KIND_RUN)
                        begin
                            visited_reg <= MAX_NODES'(1) << s_idx;
                            best_reg    <= s_idx;
                            init_reg    <= 1'b1;
                            iss_reg     <= '0;
                            p_valid_reg <= 1'b0;
                            found_reg   <= 1'b0;
                            added_reg   <= '0;
                            sum_reg     <= '0;
                        end
                    end
                S_RDWAIT:
                    pend_rv_reg <= pst_pkg::PORT_CW'(KW'(mat_rd));
                S_REPLY:
                    if (slot_free)
                    begin
                        edge_parent_reg <= '0;
                        edge_child_reg  <= '0;
                        edge_cost_reg   <= '0;
                        has_edge_reg    <= 1'b0;
                        total_cost_reg  <= '0;
                        read_value_reg  <= pend_rv_reg;
                        status_reg      <= pend_st_reg;
                        last_reg        <= 1'b1;
                    end
                S_PASS:
                begin
                    if (issuing)
                        iss_reg <= iss_reg + 1'b1;
                    p_valid_reg <= issuing;
                    p_idx_reg   <= iss_reg[IDXW-1:0];
                    if (p_valid_reg && take)
                    begin
                        found_reg   <= 1'b1;
                        min_reg     <= newd;
                        min_idx_reg <= p_idx_reg;
                    end
                end
                S_SELECT:
                begin
                    k_reg <= '0;
                    if (found_reg && (min_reg >= NO_EDGE))
                    begin
                        pend_st_reg <= pst_pkg::ST_DISCONN;
                        sum_reg     <= '0;
                    end
                    else if (found_reg)
                    begin
                        visited_reg[min_idx_reg] <= 1'b1;
                        added_reg <= added_reg + 1'b1;
                        sum_reg   <= sum_reg + min_x[pst_pkg::SUM_W-1:0];
                        best_reg  <= min_idx_reg;
                        init_reg  <= 1'b0;
                        iss_reg   <= '0;
                        found_reg <= 1'b0;
                    end
                end
                S_LNK:
                    ch_reg <= ord_rd;
                S_EDGE:
                    if (slot_free)
                    begin
                        edge_parent_reg <= par_x[pst_pkg::NODE_W-1:0];
                        edge_child_reg  <= pst_pkg::NODE_W'(ch_reg);
                        edge_cost_reg   <= dist_x[pst_pkg::PORT_CW-1:0];
                        has_edge_reg    <= 1'b1;
                        total_cost_reg  <= fin ? sum_reg : '0;
                        read_value_reg  <= '0;
                        status_reg      <= pst_pkg::ST_OK;
                        last_reg        <= fin;
                        k_reg           <= k_reg + 1'b1;
                    end
                default:
                begin
                end
            endcase

            // Take a node count write and restart the clearing sweep
            if (cfg_acc)
            begin
                node_count_reg  <= cfg_data;
                sweep_cnt_reg   <= '0;
                sweep_reply_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign edge_parent = edge_parent_reg;
    assign edge_child  = edge_child_reg;
    assign edge_cost   = edge_cost_reg;
    assign has_edge    = has_edge_reg;
    assign total_cost  = total_cost_reg;
    assign read_value  = read_value_reg;
    assign status      = status_reg;
    assign last        = last_reg;

endmodule

### rtl/pst_checker.sv
// Port-level checker for the spanning tree engine, bound to the top level.
module pst_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [pst_pkg::NODE_W-1:0]  edge_child,
    input logic [pst_pkg::PORT_CW-1:0] edge_cost,
    input logic                        has_edge,
    input logic [pst_pkg::SUM_W-1:0]   total_cost,
    input logic [1:0]                  status,
    input logic                        last
);

    // A stalled result stays valid with its edge child and cost held
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(edge_cost) && $stable(edge_child))
        else $error("result changed while stalled");

    // Only tree edges come before the final result
    a_mid_edge: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> has_edge && (total_cost == '0))
        else $error("non-final result without edge");

    // Error statuses end the item and carry no edge
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != pst_pkg::ST_OK) |-> last && !has_edge)
        else $error("error result malformed");

    // An edge result reports success
    a_edge_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_edge |-> status == pst_pkg::ST_OK)
        else $error("edge with error status");

endmodule

bind prim_spanning_tree_engine pst_checker u_pst_checker (.*);

### tb/tb_prim_spanning_tree_engine.sv
// Testbench for the Prim spanning tree engine: directed and random items checked against a predictor.
`timescale 1ns / 100ps

module tb_prim_spanning_tree_engine;

    localparam int NMAX    = 64;
    localparam int NO_LINK = 16'hFFFF;
    localparam int LIMIT   = 3000000;

    typedef struct packed {
        logic [5:0]  parent;
        logic [5:0]  child;
        logic [15:0] ecost;
        logic        has_e;
        logic [21:0] total;
        logic [15:0] rdval;
        logic [1:0]  stat;
        logic        lst;
    } tree_result_t;

    logic clk;
    logic rst_n;
    logic in_valid, in_ready;
    logic [1:0] kind;
    logic [5:0] node_a, node_b, start_node;
    logic [15:0] cost_value;
    logic out_valid, out_ready;
    logic [5:0] edge_parent, edge_child;
    logic [15:0] edge_cost, read_value;
    logic has_edge, last;
    logic [21:0] total_cost;
    logic [1:0] status;
    logic cfg_valid, cfg_ready;
    logic [6:0] cfg_data;

    // Predictor state
    logic [15:0] graph_cost [NMAX][NMAX];
    logic [6:0]  nodes_reg;
    tree_result_t pending_results[$];
    int errors;
    int cycle_count;
    int burst_left;

    prim_spanning_tree_engine DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .node_a(node_a), .node_b(node_b),
        .cost_value(cost_value), .start_node(start_node),
        .out_valid(out_valid), .out_ready(out_ready),
        .edge_parent(edge_parent), .edge_child(edge_child),
        .edge_cost(edge_cost), .has_edge(has_edge),
        .total_cost(total_cost), .read_value(read_value),
        .status(status), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int active_nodes();
        if (nodes_reg == 0) return 1;
        if (nodes_reg > NMAX) return NMAX;
        return nodes_reg;
    endfunction

    function automatic void wipe_graph();
        for (int r = 0; r < NMAX; r++)
            for (int c = 0; c < NMAX; c++)
                graph_cost[r][c] = (r == c) ? 16'd0 : 16'(NO_LINK);
    endfunction

    function automatic tree_result_t single_result(logic [1:0] st, logic [15:0] rv);
        tree_result_t r;
        r = '0;
        r.stat = st;
        r.rdval = rv;
        r.lst = 1'b1;
        return r;
    endfunction

    // Append one expected result behind the others
    function automatic void expect_result(tree_result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Compute expected results of one item and queue them
    function automatic void predict_item(logic [1:0] k, logic [5:0] a, logic [5:0] b,
                                         logic [15:0] c, logic [5:0] s);
        int n;
        logic [16:0] link_cost [NMAX];
        logic [5:0]  link_from [NMAX];
        bit          in_tree [NMAX];
        int          order [NMAX];
        int          added;
        logic [21:0] sum;
        int best;
        tree_result_t r;
        n = active_nodes();
        added = 0;
        case (pst_pkg::kind_t'(k))
            pst_pkg::KIND_WRITE:
            begin
                if (a >= n || b >= n || a == b || c >= NO_LINK)
                    expect_result(single_result(pst_pkg::ST_REJECT, 16'd0));
                else
                begin
                    graph_cost[a][b] = c;
                    graph_cost[b][a] = c;
                    expect_result(single_result(pst_pkg::ST_OK, 16'd0));
                end
            end
            pst_pkg::KIND_READ:
                expect_result(single_result(pst_pkg::ST_OK,
                    (a >= n || b >= n) ? 16'(NO_LINK) : graph_cost[a][b]));
            pst_pkg::KIND_CLEAR:
            begin
                wipe_graph();
                expect_result(single_result(pst_pkg::ST_OK, 16'd0));
            end
            default:
            begin
                if (s >= n)
                    expect_result(single_result(pst_pkg::ST_BAD_START, 16'd0));
                else if (n == 1)
                    expect_result(single_result(pst_pkg::ST_OK, 16'd0));
                else
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        link_cost[i] = NO_LINK;
                        link_from[i] = '0;
                        in_tree[i] = 0;
                    end
                    link_cost[s] = 0;
                    sum = '0;
                    // Grow the tree one cheapest node at a time
                    for (int step = 0; step < n; step++)
                    begin
                        best = -1;
                        for (int i = 0; i < n; i++)
                            if (!in_tree[i] && (best < 0 || link_cost[i] < link_cost[best]))
                                best = i;
                        if (best < 0 || link_cost[best] >= NO_LINK)
                        begin
                            expect_result(single_result(pst_pkg::ST_DISCONN, 16'd0));
                            return;
                        end
                        in_tree[best] = 1;
                        if (best != s)
                        begin
                            order[added] = best;
                            added++;
                            sum += link_cost[best][15:0];
                        end
                        for (int i = 0; i < n; i++)
                            if (!in_tree[i] && graph_cost[best][i] < link_cost[i])
                            begin
                                link_cost[i] = graph_cost[best][i];
                                link_from[i] = 6'(best);
                            end
                    end
                    for (int j = 0; j < added; j++)
                    begin
                        r = '0;
                        r.parent = link_from[order[j]];
                        r.child = 6'(order[j]);
                        r.ecost = link_cost[order[j]][15:0];
                        r.has_e = 1'b1;
                        r.lst = (j == added - 1);
                        r.total = r.lst ? sum : '0;
                        expect_result(r);
                    end
                end
            end
        endcase
    endfunction

    // Check each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        tree_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (edge_parent !== exp_r.parent)
                begin
                    $error("edge_parent exp %0d got %0d", exp_r.parent, edge_parent);
                    errors++;
                end
                if (edge_child !== exp_r.child)
                begin
                    $error("edge_child exp %0d got %0d", exp_r.child, edge_child);
                    errors++;
                end
                if (edge_cost !== exp_r.ecost)
                begin
                    $error("edge_cost exp %0d got %0d", exp_r.ecost, edge_cost);
                    errors++;
                end
                if (has_edge !== exp_r.has_e)
                begin
                    $error("has_edge exp %0d got %0d", exp_r.has_e, has_edge);
                    errors++;
                end
                if (total_cost !== exp_r.total)
                begin
                    $error("total_cost exp %0d got %0d", exp_r.total, total_cost);
                    errors++;
                end
                if (read_value !== exp_r.rdval)
                begin
                    $error("read_value exp %0d got %0d", exp_r.rdval, read_value);
                    errors++;
                end
                if (status !== exp_r.stat)
                begin
                    $error("status exp %0d got %0d", exp_r.stat, status);
                    errors++;
                end
                if (last !== exp_r.lst)
                begin
                    $error("last exp %0d got %0d", exp_r.lst, last);
                    errors++;
                end
            end
        end
    end

    // Stall the receiver on its own pattern, with long open stretches
    always @(posedge clk)
    begin
        if (cycle_count % 2000 < 700)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    // Send one item, with bursts and random gaps
    task automatic send_item(logic [1:0] k, logic [5:0] a, logic [5:0] b,
                             logic [15:0] c, logic [5:0] s);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(0, 4)) @(posedge clk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        in_valid <= 1'b1;
        kind <= k;
        node_a <= a;
        node_b <= b;
        cost_value <= c;
        start_node <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_item(k, a, b, c, s);
        // Drop valid between items; the engine is busy after a transaction anyway
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until all results are in, then idle a little
    task automatic drain();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_node_count(logic [6:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        nodes_reg = v;
        wipe_graph();
    endtask

    task automatic test_reset_state();
        send_item(pst_pkg::KIND_READ, 6'd0, 6'd0, 16'd0, 6'd0);
        send_item(pst_pkg::KIND_RUN, 6'd0, 6'd0, 16'd0, 6'd0);
        send_item(pst_pkg::KIND_RUN, 6'd0, 6'd0, 16'd0, 6'd63);
        send_item(pst_pkg::KIND_WRITE, 6'd0, 6'd1, 16'd5, 6'd0);
    endtask

    task automatic test_directed_graph();
        write_node_count(7'd4);
        send_item(pst_pkg::KIND_WRITE, 6'd0, 6'd0, 16'd3, 6'd0);
        send_item(pst_pkg::KIND_WRITE, 6'd0, 6'd1, 16'hFFFF, 6'd0);
        send_item(pst_pkg::KIND_WRITE, 6'd0, 6'd4, 16'd1, 6'd0);
        send_item(pst_pkg::KIND_WRITE, 6'd63, 6'd1, 16'd1, 6'd0);
        send_item(pst_pkg::KIND_WRITE, 6'd0, 6'd1, 16'hFFFE, 6'd0);
        send_item(pst_pkg::KIND_WRITE, 6'd1, 6'd2, 16'd0, 6'd0);
        send_item(pst_pkg::KIND_RUN, 6'd0, 6'd0, 16'd0, 6'd0);
        send_item(pst_pkg::KIND_WRITE, 6'd2, 6'd3, 16'd7, 6'd0);
        send_item(pst_pkg::KIND_WRITE, 6'd0, 6'd3, 16'd7, 6'd0);
        send_item(pst_pkg::KIND_READ, 6'd3, 6'd2, 16'd0, 6'd0);
        send_item(pst_pkg::KIND_READ, 6'd63, 6'd2, 16'd0, 6'd0);
        send_item(pst_pkg::KIND_RUN, 6'd0, 6'd0, 16'd0, 6'd3);
        send_item(pst_pkg::KIND_RUN, 6'd0, 6'd0, 16'd0, 6'd4);
        send_item(pst_pkg::KIND_CLEAR, 6'd0, 6'd0, 16'd0, 6'd0);
        send_item(pst_pkg::KIND_READ, 6'd1, 6'd2, 16'd0, 6'd0);
        send_item(pst_pkg::KIND_READ, 6'd2, 6'd2, 16'd0, 6'd0);
        write_node_count(7'd0);
        send_item(pst_pkg::KIND_RUN, 6'd0, 6'd0, 16'd0, 6'd0);
        write_node_count(7'd127);
        send_item(pst_pkg::KIND_WRITE, 6'd63, 6'd62, 16'd9, 6'd0);
        send_item(pst_pkg::KIND_READ, 6'd62, 6'd63, 16'd0, 6'd0);
        send_item(pst_pkg::KIND_RUN, 6'd0, 6'd0, 16'd0, 6'd63);
    endtask

    // Build mostly connected random graphs, then run from random roots
    task automatic test_random_graphs(int n, int items);
        int m;
        int a;
        write_node_count(7'(n));
        m = active_nodes();
        for (int i = 1; i < m; i++)
            send_item(pst_pkg::KIND_WRITE, 6'($urandom_range(0, i - 1)), 6'(i),
                      16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 65534)
                                                    : $urandom_range(0, 20)),
                      6'($urandom));
        for (int i = 0; i < items; i++)
        begin
            a = $urandom_range(0, 9);
            if (a < 4)
                send_item(pst_pkg::KIND_WRITE, 6'($urandom_range(0, m)),
                          6'($urandom_range(0, m)),
                          16'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 30)),
                          6'($urandom));
            else if (a < 6)
                send_item(pst_pkg::KIND_READ, 6'($urandom_range(0, m)), 6'($urandom),
                          16'($urandom), 6'($urandom));
            else if (a < 9)
                send_item(pst_pkg::KIND_RUN, 6'($urandom), 6'($urandom), 16'($urandom),
                          6'($urandom_range(0, m)));
            else if ($urandom_range(0, 3) == 0)
                send_item(pst_pkg::KIND_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom),
                          6'($urandom));
            else
                send_item(pst_pkg::KIND_RUN, 6'($urandom), 6'($urandom), 16'($urandom),
                          6'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = '0;
        node_a = '0;
        node_b = '0;
        cost_value = '0;
        start_node = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        errors = 0;
        cycle_count = 0;
        burst_left = 0;
        nodes_reg = 7'd1;
        wipe_graph();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed_graph();
        test_random_graphs(5, 25);
        test_random_graphs(2, 10);
        test_random_graphs(9, 20);
        test_random_graphs(3, 10);
        test_random_graphs(64, 6);
        drain();

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
rtl/pst_pkg.sv
rtl/pst_ram.sv
rtl/pst_relax.sv
rtl/prim_spanning_tree_engine.sv
rtl/pst_checker.sv
tb/tb_prim_spanning_tree_engine.sv
